>>> hdl/smc_pkg.sv
package smc_pkg;

    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;
    localparam int POS_W     = 18;

    typedef logic [WORD_BITS-1:0] word_t;

    localparam word_t WORD_MSB  = 32'h8000_0000;
    localparam word_t WORD_ZERO = 32'h0000_0000;

    localparam logic [2:0] CFG_KEY_COLOUR    = 3'd0;
    localparam logic [2:0] CFG_FIRST_WIDTH   = 3'd1;
    localparam logic [2:0] CFG_FIRST_HEIGHT  = 3'd2;
    localparam logic [2:0] CFG_SECOND_WIDTH  = 3'd3;
    localparam logic [2:0] CFG_SECOND_HEIGHT = 3'd4;

    typedef struct packed {
        word_t            ma;
        word_t            mb;
        word_t            nb;
        logic [BIT_W-1:0] skip_bits;
        logic             use_next;
    } word_op_t;

endpackage

>>> hdl/sprite_mask_collision_core.sv
// Load beat: after accept the core passes a read state and a write state before the next beat can be taken.
// Test beat: sum, geometry, and if the sprites overlap a first read, then per mask word
// compared (intersection rows times words per row, fewer on an early hit) a read and an
// evaluate step, then done. Each word step needs three mask reads over the two RAM read ports.
// Reset: asynchronous, clears control, counters and key; sizes go to 64; mask RAM is not cleared.
module sprite_mask_collision_core #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic               sprite_sel,
    input  logic [7:0]         pixel,
    input  logic signed [15:0] first_x,
    input  logic signed [15:0] first_y,
    input  logic signed [15:0] second_x,
    input  logic signed [15:0] second_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               collides
);

    localparam int WPR = (MAX_WIDTH + smc_pkg::WORD_BITS - 1) / smc_pkg::WORD_BITS;
    localparam int WW  = (WPR > 1) ? $clog2(WPR) : 1;
    localparam int NW  = WW + 1;
    localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WCW = $clog2(MAX_WIDTH + 1);
    localparam int HCW = $clog2(MAX_HEIGHT + 1);
    localparam int AW  = 1 + RW + WW;
    localparam int BW  = smc_pkg::BIT_W;
    localparam int PW  = smc_pkg::POS_W;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_LD_RD = 9'b000000010,
        S_LD_WR = 9'b000000100,
        S_SUM   = 9'b000001000,
        S_GEO   = 9'b000010000,
        S_RD    = 9'b000100000,
        S_NX    = 9'b001000000,
        S_EV    = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [7:0]    key_reg;
    logic [6:0]    size_w_reg [2];
    logic [6:0]    size_h_reg [2];
    logic [CW-1:0] col_reg [2];
    logic [RW-1:0] row_reg [2];
    logic          out_valid_reg;

    logic                  sel_reg;
    logic                  opaque_reg;
    logic signed [15:0]    x1_reg, y1_reg, x2_reg, y2_reg;
    logic signed [PW-1:0]  e1_reg, e2_reg, f1_reg, f2_reg;
    logic                  sa_reg;
    logic [RW-1:0]         a_row_reg, b_row_reg;
    logic [HCW-1:0]        rows_left_reg;
    logic [NW-1:0]         n_a_reg, sw_reg, wpr_b_reg, bw_reg;
    logic [BW-1:0]         skip_reg;
    logic [WW-1:0]         j_reg;
    smc_pkg::word_t        ma_reg, mb_reg;
    logic                  use_next_reg;
    logic                  hit_reg;
    logic                  collides_reg;
    logic [AW-1:0]         ld_addr_reg;
    logic [BW-1:0]         ld_bit_reg;

    logic [WCW-1:0] w_eff [2];
    logic [HCW-1:0] h_eff [2];

    logic           in_accept;
    logic           out_free;

    // load datapath
    logic [WCW-1:0] ld_w;
    logic [HCW-1:0] ld_h;
    logic           ld_wrap;
    logic [CW-1:0]  ld_col, ld_col_next;
    logic [RW-1:0]  ld_row, ld_row_next;
    logic [CW:0]    ld_col_inc;
    logic [RW:0]    ld_row_inc;
    logic           ld_col_end, ld_row_end;
    logic [AW-1:0]  ld_addr;
    smc_pkg::word_t ld_word;

    // geometry
    logic signed [PW-1:0] x1p, y1p, x2p, y2p, w1p, h1p, w2p, h2p;
    logic signed [PW-1:0] xa, xb, ya, yb, iy, emin, fmin, iw, ih, ra, rb, off, iw_round;
    logic                 a_first;
    logic                 overlap;
    logic [WCW-1:0]       wb;
    logic [WCW:0]         wb_round;

    // walk
    logic [NW-1:0]  j_inc, bw_inc;
    logic           word_more, last_row, walk_done;
    logic [WW-1:0]  j_nx, rd_j;
    logic [NW-1:0]  bw_nx, rd_bw;
    logic [RW-1:0]  a_row_nx, b_row_nx, rd_a_row, rd_b_row;
    logic [AW-1:0]  a_addr, b_addr, nb_addr;

    logic [AW-1:0]      raddr0, raddr1;
    smc_pkg::word_t     rdata0, rdata1;
    logic               mem_we;
    smc_pkg::word_op_t  word_op;
    logic               word_hit;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign collides  = collides_reg;

    always_comb
    begin
        for (int s = 0; s < 2; s++)
        begin
            if (size_w_reg[s] == 7'd0)
                w_eff[s] = WCW'(1);
            else if (int'(size_w_reg[s]) > MAX_WIDTH)
                w_eff[s] = WCW'(MAX_WIDTH);
            else
                w_eff[s] = WCW'(size_w_reg[s]);

            if (size_h_reg[s] == 7'd0)
                h_eff[s] = HCW'(1);
            else if (int'(size_h_reg[s]) > MAX_HEIGHT)
                h_eff[s] = HCW'(MAX_HEIGHT);
            else
                h_eff[s] = HCW'(size_h_reg[s]);
        end
    end

    // ---------------- load: read-modify-write of one mask word ----------------
    assign ld_w    = w_eff[sel_reg];
    assign ld_h    = h_eff[sel_reg];
    assign ld_wrap = ({1'b0, col_reg[sel_reg]} >= (CW + 1)'(ld_w))
                  || ({1'b0, row_reg[sel_reg]} >= (RW + 1)'(ld_h));
    assign ld_col  = ld_wrap ? '0 : col_reg[sel_reg];
    assign ld_row  = ld_wrap ? '0 : row_reg[sel_reg];

    assign ld_col_inc  = {1'b0, ld_col} + (CW + 1)'(1);
    assign ld_row_inc  = {1'b0, ld_row} + (RW + 1)'(1);
    assign ld_col_end  = ld_col_inc >= (CW + 1)'(ld_w);
    assign ld_row_end  = ld_row_inc >= (RW + 1)'(ld_h);
    assign ld_col_next = ld_col_end ? '0 : ld_col_inc[CW-1:0];
    assign ld_row_next = ld_col_end ? (ld_row_end ? '0 : ld_row_inc[RW-1:0]) : ld_row;
    assign ld_addr     = {sel_reg, ld_row, WW'(ld_col >> BW)};

    assign ld_word = ((ld_bit_reg == '0) ? smc_pkg::WORD_ZERO : rdata0)
                   | (opaque_reg ? (smc_pkg::WORD_MSB >> ld_bit_reg) : smc_pkg::WORD_ZERO);

    // ---------------- test geometry ----------------
    assign x1p = {{(PW - 16){x1_reg[15]}}, x1_reg};
    assign y1p = {{(PW - 16){y1_reg[15]}}, y1_reg};
    assign x2p = {{(PW - 16){x2_reg[15]}}, x2_reg};
    assign y2p = {{(PW - 16){y2_reg[15]}}, y2_reg};
    assign w1p = $signed({{(PW - WCW){1'b0}}, w_eff[0]});
    assign h1p = $signed({{(PW - HCW){1'b0}}, h_eff[0]});
    assign w2p = $signed({{(PW - WCW){1'b0}}, w_eff[1]});
    assign h2p = $signed({{(PW - HCW){1'b0}}, h_eff[1]});

    // a is the sprite further right (second on a tie); b is walked at a word/bit offset
    assign a_first  = x1p > x2p;
    assign xa       = a_first ? x1p : x2p;
    assign xb       = a_first ? x2p : x1p;
    assign ya       = a_first ? y1p : y2p;
    assign yb       = a_first ? y2p : y1p;
    assign iy       = (y1p > y2p) ? y1p : y2p;
    assign emin     = (e1_reg < e2_reg) ? e1_reg : e2_reg;
    assign fmin     = (f1_reg < f2_reg) ? f1_reg : f2_reg;
    assign iw       = emin - xa;
    assign ih       = fmin - iy;
    assign ra       = iy - ya;
    assign rb       = iy - yb;
    assign off      = xa - xb;
    assign iw_round = iw + PW'(smc_pkg::WORD_BITS - 1);
    assign overlap  = (x2p < e1_reg) && (x1p < e2_reg) && (y2p < f1_reg) && (y1p < f2_reg);
    assign wb       = a_first ? w_eff[1] : w_eff[0];
    assign wb_round = {1'b0, wb} + (WCW + 1)'(smc_pkg::WORD_BITS - 1);

    // ---------------- word walk ----------------
    assign j_inc     = NW'(j_reg) + NW'(1);
    assign bw_inc    = bw_reg + NW'(1);
    assign word_more = j_inc < n_a_reg;
    assign last_row  = rows_left_reg == HCW'(1);
    assign walk_done = !word_more && last_row;
    assign j_nx      = word_more ? j_inc[WW-1:0] : '0;
    assign bw_nx     = word_more ? bw_inc : sw_reg;
    assign a_row_nx  = word_more ? a_row_reg : a_row_reg + RW'(1);
    assign b_row_nx  = word_more ? b_row_reg : b_row_reg + RW'(1);

    assign rd_j     = (state_reg == S_EV) ? j_nx     : j_reg;
    assign rd_bw    = (state_reg == S_EV) ? bw_nx    : bw_reg;
    assign rd_a_row = (state_reg == S_EV) ? a_row_nx : a_row_reg;
    assign rd_b_row = (state_reg == S_EV) ? b_row_nx : b_row_reg;

    assign a_addr  = {sa_reg, rd_a_row, rd_j};
    assign b_addr  = {~sa_reg, rd_b_row, rd_bw[WW-1:0]};
    assign nb_addr = {~sa_reg, b_row_reg, bw_inc[WW-1:0]};

    assign raddr0 = (state_reg == S_LD_RD) ? ld_addr : a_addr;
    assign raddr1 = (state_reg == S_NX) ? nb_addr : b_addr;
    assign mem_we = (state_reg == S_LD_WR);

    assign word_op.ma        = ma_reg;
    assign word_op.mb        = mb_reg;
    assign word_op.nb        = rdata1;
    assign word_op.skip_bits = skip_reg;
    assign word_op.use_next  = use_next_reg;

    smc_mask_ram #(
        .ADDR_W (AW)
    ) u_ram (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (ld_addr_reg),
        .wdata  (ld_word),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

    smc_word_unit u_word (
        .op  (word_op),
        .hit (word_hit)
    );

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = op ? S_SUM : S_LD_RD;
            end
            S_LD_RD: state_next = S_LD_WR;
            S_LD_WR: state_next = S_IDLE;
            S_SUM:   state_next = S_GEO;
            S_GEO:   state_next = overlap ? S_RD : S_DONE;
            S_RD:    state_next = S_NX;
            S_NX:    state_next = S_EV;
            S_EV:    state_next = (word_hit || walk_done) ? S_DONE : S_NX;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            key_reg       <= 8'd0;
            size_w_reg[0] <= 7'd64;
            size_w_reg[1] <= 7'd64;
            size_h_reg[0] <= 7'd64;
            size_h_reg[1] <= 7'd64;
            col_reg[0]    <= '0;
            col_reg[1]    <= '0;
            row_reg[0]    <= '0;
            row_reg[1]    <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (state_reg == S_LD_RD)
            begin
                col_reg[sel_reg] <= ld_col_next;
                row_reg[sel_reg] <= ld_row_next;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    smc_pkg::CFG_KEY_COLOUR:
                    begin
                        key_reg <= cfg_data;
                    end
                    smc_pkg::CFG_FIRST_WIDTH:
                    begin
                        size_w_reg[0] <= cfg_data[6:0];
                        col_reg[0]    <= '0;
                        row_reg[0]    <= '0;
                    end
                    smc_pkg::CFG_FIRST_HEIGHT:
                    begin
                        size_h_reg[0] <= cfg_data[6:0];
                        col_reg[0]    <= '0;
                        row_reg[0]    <= '0;
                    end
                    smc_pkg::CFG_SECOND_WIDTH:
                    begin
                        size_w_reg[1] <= cfg_data[6:0];
                        col_reg[1]    <= '0;
                        row_reg[1]    <= '0;
                    end
                    smc_pkg::CFG_SECOND_HEIGHT:
                    begin
                        size_h_reg[1] <= cfg_data[6:0];
                        col_reg[1]    <= '0;
                        row_reg[1]    <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sel_reg    <= sprite_sel;
            opaque_reg <= (pixel != key_reg);
            x1_reg     <= first_x;
            y1_reg     <= first_y;
            x2_reg     <= second_x;
            y2_reg     <= second_y;
        end

        if (state_reg == S_LD_RD)
        begin
            ld_addr_reg <= ld_addr;
            ld_bit_reg  <= ld_col[BW-1:0];
        end

        if (state_reg == S_SUM)
        begin
            e1_reg <= x1p + w1p;
            e2_reg <= x2p + w2p;
            f1_reg <= y1p + h1p;
            f2_reg <= y2p + h2p;
        end

        if (state_reg == S_GEO)
        begin
            hit_reg       <= 1'b0;
            sa_reg        <= !a_first;
            a_row_reg     <= RW'(ra);
            b_row_reg     <= RW'(rb);
            rows_left_reg <= HCW'(ih);
            n_a_reg       <= NW'(iw_round >>> BW);
            sw_reg        <= NW'(off >>> BW);
            bw_reg        <= NW'(off >>> BW);
            skip_reg      <= off[BW-1:0];
            wpr_b_reg     <= NW'(wb_round >> BW);
            j_reg         <= '0;
        end

        if (state_reg == S_NX)
        begin
            ma_reg       <= rdata0;
            mb_reg       <= rdata1;
            use_next_reg <= (skip_reg != '0) && (bw_inc < wpr_b_reg);
        end

        if (state_reg == S_EV)
        begin
            hit_reg   <= word_hit;
            j_reg     <= j_nx;
            bw_reg    <= bw_nx;
            a_row_reg <= a_row_nx;
            b_row_reg <= b_row_nx;
            if (!word_more)
                rows_left_reg <= rows_left_reg - HCW'(1);
        end

        if (state_reg == S_DONE && out_free)
            collides_reg <= hit_reg;
    end

    // ---------------- checks ----------------
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result beat raised outside the done step");

    a_load_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !op) |=> ##1 mem_we)
        else $error("load beat did not write its mask word");

    a_word_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EV) |-> (NW'(j_reg) < n_a_reg))
        else $error("word walk ran past the intersection");

    a_stall_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !out_free) |=> (state_reg == S_DONE) && in_stall)
        else $error("test left done while result register was full");

endmodule

>>> hdl/smc_mask_ram.sv
module smc_mask_ram #(
    parameter int ADDR_W = 8
) (
    input  logic                clk,
    input  logic                we,
    input  logic [ADDR_W-1:0]   waddr,
    input  smc_pkg::word_t      wdata,
    input  logic [ADDR_W-1:0]   raddr0,
    input  logic [ADDR_W-1:0]   raddr1,
    output smc_pkg::word_t      rdata0,
    output smc_pkg::word_t      rdata1
);

    smc_pkg::word_t mem [0:(1 << ADDR_W) - 1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

>>> hdl/smc_word_unit.sv
module smc_word_unit (
    input  smc_pkg::word_op_t op,
    output logic              hit
);

    smc_pkg::word_t aligned;
    smc_pkg::word_t spill;
    logic [smc_pkg::BIT_W:0] spill_shift;

    // a word lines up against b word; its tail meets the head of the next b word
    assign spill_shift = (smc_pkg::BIT_W + 1)'(smc_pkg::WORD_BITS) - {1'b0, op.skip_bits};
    assign aligned     = (op.ma >> op.skip_bits) & op.mb;
    assign spill       = op.use_next ? (op.ma & (op.nb >> spill_shift)) : smc_pkg::WORD_ZERO;
    assign hit         = |(aligned | spill);

endmodule
